[rtl/theater_chase_frame_generator_macros.svh]
// Assertion macros shared by the theater-chase frame generator RTL.
// Depends on nothing; files that assert include it by name.
// Defining ASSERT_OFF turns every macro into an empty statement.
`ifndef THEATER_CHASE_FRAME_GENERATOR_MACROS_SVH
`define THEATER_CHASE_FRAME_GENERATOR_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked check on clk, held off while rst is high.
`define TCH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check on clk that also holds during reset.
`define TCH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TCH_ASSERT(lbl, prop, msg)
`define TCH_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

[rtl/tchase_pkg.sv]
// Shared types, register indexes and helpers of the theater-chase generator.
// Depends on nothing; used by the register block, the interfaces and the top.
package tchase_pkg;

  localparam int TIME_W  = 32;
  localparam int RUN_W   = 8;
  localparam int COLOR_W = 32;
  localparam int CNT_W   = 7;
  localparam int IDX_W   = 6;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  // Register indexes, byte address divided by four.
  typedef enum logic [2:0] {
    REG_INTERVAL = 3'd0,
    REG_RUN_ON   = 3'd1,
    REG_RUN_OFF  = 3'd2,
    REG_COLOR    = 3'd3,
    REG_REVERSE  = 3'd4,
    REG_NUM_PIX  = 3'd5
  } reg_idx_t;

  // Configuration as seen by the frame sequencer.
  typedef struct packed {
    logic [TIME_W-1:0]  interval_ms;
    logic [RUN_W-1:0]   run_on;
    logic [RUN_W-1:0]   run_off;
    logic [COLOR_W-1:0] color;
    logic               reverse;
    logic [CNT_W-1:0]   num_pixels;
  } cfg_t;

  // A run length of zero behaves as one.
  function automatic logic [RUN_W-1:0] eff_run(input logic [RUN_W-1:0] r);
    return (r == '0) ? RUN_W'(1) : r;
  endfunction

endpackage

[rtl/tchase_in_if.sv]
// Request channel carrying one millisecond timestamp per request.
// Depends on tchase_pkg for the field width.
interface tchase_in_if;
  logic                        valid;
  logic                        ready;
  logic [tchase_pkg::TIME_W-1:0] now_ms;

  modport source (output valid, output now_ms, input ready);
  modport sink   (input valid, input now_ms, output ready);
endinterface

[rtl/tchase_out_if.sv]
// Pixel channel carrying one strip write per request.
// Depends on tchase_pkg for the field widths.
interface tchase_out_if;
  logic                          valid;
  logic                          ready;
  logic [tchase_pkg::IDX_W-1:0]   pixel_index;
  logic [tchase_pkg::COLOR_W-1:0] pixel_color;
  logic                          frame_end;

  modport source (output valid, output pixel_index, output pixel_color, output frame_end,
                  input ready);
  modport sink   (input valid, input pixel_index, input pixel_color, input frame_end,
                  output ready);
endinterface

[rtl/tchase_regs.sv]
// APB-style configuration registers of the theater-chase generator.
// Depends on tchase_pkg for the register map and the cfg_t struct.
module tchase_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tchase_pkg::ADDR_W-1:0] paddr,
  input  logic [tchase_pkg::DATA_W-1:0] pwdata,
  output logic [tchase_pkg::DATA_W-1:0] prdata,
  output logic                          pready,
  output tchase_pkg::cfg_t              cfg
);
  import tchase_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

  // Register writes; indexes beyond the map are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.interval_ms <= TIME_W'(50);
      cfg.run_on      <= RUN_W'(3);
      cfg.run_off     <= RUN_W'(3);
      cfg.color       <= COLOR_W'(32'h00FF_FFFF);
      cfg.reverse     <= 1'b1;
      cfg.num_pixels  <= CNT_W'(64);
    end else if (wr_en) begin
      case (idx)
        REG_INTERVAL: cfg.interval_ms <= pwdata[TIME_W-1:0];
        REG_RUN_ON:   cfg.run_on      <= pwdata[RUN_W-1:0];
        REG_RUN_OFF:  cfg.run_off     <= pwdata[RUN_W-1:0];
        REG_COLOR:    cfg.color       <= pwdata[COLOR_W-1:0];
        REG_REVERSE:  cfg.reverse     <= pwdata[0];
        REG_NUM_PIX:  cfg.num_pixels  <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux, zero extended.
  always_comb begin
    prdata = '0;
    case (idx)
      REG_INTERVAL: prdata = DATA_W'(cfg.interval_ms);
      REG_RUN_ON:   prdata = DATA_W'(cfg.run_on);
      REG_RUN_OFF:  prdata = DATA_W'(cfg.run_off);
      REG_COLOR:    prdata = DATA_W'(cfg.color);
      REG_REVERSE:  prdata = DATA_W'(cfg.reverse);
      REG_NUM_PIX:  prdata = DATA_W'(cfg.num_pixels);
      default:      prdata = '0;
    endcase
  end

endmodule

[rtl/theater_chase_frame_generator.sv]
// Theater-chase frame generator top level: timer check and pixel sequencer.
// Depends on tchase_pkg, tchase_in_if, tchase_out_if, tchase_regs and the macro header.
//
//   channel  | kind        | payload
//   ---------+-------------+------------------------------------------
//   stamp    | request in  | now_ms
//   pixel    | request out | pixel_index, pixel_color, frame_end
//   apb      | config      | six registers at byte addresses 0..20
//
// A timestamp is accepted in the idle state and checked in the check state.
// A due frame then sends one pixel per cycle while pixel is not stalled, then
// advances the chase phase; a new timestamp is taken only back in idle.
// The single pixel output register sets the pace; a stall on pixel holds the
// sequencer. Reset is synchronous; no clearing pass is needed after it.
`include "theater_chase_frame_generator_macros.svh"

module theater_chase_frame_generator #(
  parameter int unsigned MAX_PIXELS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  tchase_in_if.sink                     stamp,
  tchase_out_if.source                  pixel,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tchase_pkg::ADDR_W-1:0] paddr,
  input  logic [tchase_pkg::DATA_W-1:0] pwdata,
  output logic [tchase_pkg::DATA_W-1:0] prdata,
  output logic                          pready
);
  import tchase_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_CHECK   = 4'b0010,
    S_EMIT    = 4'b0100,
    S_ADVANCE = 4'b1000
  } state_t;

  cfg_t              cfg;
  state_t            state;
  logic [TIME_W-1:0] now_q;
  logic [TIME_W-1:0] last_frame_time;
  logic              fresh;
  logic              phase_lit;
  logic [RUN_W-1:0]  phase_count;
  logic              lit;
  logic [RUN_W-1:0]  left;
  logic [CNT_W-1:0]  pix_cnt;
  logic [CNT_W-1:0]  n_frame;
  logic              out_valid;
  logic [IDX_W-1:0]  out_index;
  logic [COLOR_W-1:0] out_color;
  logic              out_end;

  logic [TIME_W-1:0] elapsed;
  logic              fire;
  logic [CNT_W-1:0]  n_eff;
  logic              slot_free;
  logic              last_pix;
  logic [CNT_W-1:0]  pos;
  logic [RUN_W:0]    count_inc;
  logic [RUN_W-1:0]  run_lim;

  tchase_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Interval check: elapsed time (wrapping) against the interval; always fires after reset.
  assign elapsed = now_q - last_frame_time;
  assign fire    = fresh || (elapsed >= cfg.interval_ms);

  // Pixel count clamped to the strip in use.
  always_comb begin
    priority if (cfg.num_pixels == '0) begin
      n_eff = CNT_W'(1);
    end else if (cfg.num_pixels > CNT_W'(MAX_PIXELS)) begin
      n_eff = CNT_W'(MAX_PIXELS);
    end else begin
      n_eff = cfg.num_pixels;
    end
  end

  // Per-pixel position and frame end.
  assign slot_free = !out_valid || pixel.ready;
  assign last_pix  = (pix_cnt + CNT_W'(1)) == n_frame;
  assign pos       = cfg.reverse ? (n_frame - CNT_W'(1) - pix_cnt) : pix_cnt;

  // Phase advance after a frame, with one extra bit so the count never wraps.
  assign count_inc = {1'b0, phase_count} + (RUN_W+1)'(1);
  assign run_lim   = phase_lit ? eff_run(cfg.run_on) : eff_run(cfg.run_off);

  assign stamp.ready = (state == S_IDLE);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      last_frame_time <= '0;
      fresh           <= 1'b1;
      phase_lit       <= 1'b1;
      phase_count     <= RUN_W'(1);
      pix_cnt         <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (stamp.valid) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (fire) begin
            fresh           <= 1'b0;
            last_frame_time <= now_q;
            pix_cnt         <= '0;
            state           <= S_EMIT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            pix_cnt <= pix_cnt + CNT_W'(1);
            if (last_pix) begin
              state <= S_ADVANCE;
            end
          end
        end
        S_ADVANCE: begin
          if (count_inc > {1'b0, run_lim}) begin
            phase_count <= RUN_W'(1);
            phase_lit   <= !phase_lit;
          end else begin
            phase_count <= count_inc[RUN_W-1:0];
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Frame working registers: timestamp, pixel count, run phase and remaining run length.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && stamp.valid) begin
      now_q <= stamp.now_ms;
    end
    if (state == S_CHECK) begin
      n_frame <= n_eff;
      lit     <= phase_lit;
      left    <= (phase_count == '0) ? RUN_W'(1) : phase_count;
    end else if (state == S_EMIT && slot_free) begin
      if (left == RUN_W'(1)) begin
        lit  <= !lit;
        left <= lit ? eff_run(cfg.run_off) : eff_run(cfg.run_on);
      end else begin
        left <= left - RUN_W'(1);
      end
    end
  end

  // Output register: valid is control, the payload loads with each pixel.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT && slot_free) begin
      out_valid <= 1'b1;
    end else if (pixel.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && slot_free) begin
      out_index <= pos[IDX_W-1:0];
      out_color <= lit ? cfg.color : '0;
      out_end   <= last_pix;
    end
  end

  assign pixel.valid       = out_valid;
  assign pixel.pixel_index = out_index;
  assign pixel.pixel_color = out_color;
  assign pixel.frame_end   = out_end;

  // Checks on the sequencer.
  `TCH_ASSERT(a_emit_in_range, (state == S_EMIT) |-> (pix_cnt < n_frame), "pixel count past frame")
  `TCH_ASSERT(a_advance_after_end, (state == S_ADVANCE) |-> (out_valid && out_end), "advance without frame end")
  `TCH_ASSERT(a_check_exit, (state == S_CHECK) |=> (state == S_EMIT || state == S_IDLE), "bad exit from check")
  `TCH_ASSERT(a_count_nonzero, (phase_count != '0), "phase count reached zero")

endmodule
